// ===== hdl/esk_pkg.sv =====
`default_nettype none
package esk_pkg;

    localparam int ARG_W   = 22;
    localparam int BETA_W  = 22;
    localparam int SCALE_W = 25;
    localparam int CFG_W   = 25;
    localparam int MANT_W  = 24;
    localparam int EXPO_W  = 6;
    localparam int FRAC_W  = 24;

    // register indexes of the configuration port
    localparam logic CFG_BETA_GAIN   = 1'b0;
    localparam logic CFG_WIDTH_SCALE = 1'b1;

    localparam logic [BETA_W-1:0]  BETA_RESET  = 22'd1658061;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd554619;

    // log2(e) in Q1.30
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [57:0] ONE_Q56   = 58'h100_0000_0000_0000;

    localparam logic [MANT_W-1:0] MANT_MAX = 24'hFFFFFF;
    localparam logic [EXPO_W-1:0] EXPO_MAX = 6'd63;

    // square root: 25 result bits, 5 per stage
    localparam int SQ_STAGES = 5;
    localparam int SQ_STEPS  = 5;

    typedef struct packed {
        logic signed [ARG_W-1:0] arg_value;
        logic                    end_of_vector;
    } t_in;

    typedef struct packed {
        logic [MANT_W-1:0] kernel_mantissa;
        logic [EXPO_W-1:0] kernel_exponent;
        logic              out_of_support;
        logic              end_of_vector_out;
    } t_out;

    typedef struct packed {
        logic [26:0] rem;
        logic [24:0] root;
        logic [49:0] vsh;
    } t_sq;

    typedef struct packed {
        logic              eov;
        logic              oos;
        logic              sat;
        logic [EXPO_W-1:0] expo;
    } t_tag;

    // bitwise integer square root, elaboration use only
    function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.31
    function automatic logic [31:0] exp_tap(input int k);
        logic [63:0] t;
        t = isqrt_c(64'h8000_0000_0000_0000);
        for (int i = 2; i <= k; i++) begin
            t = isqrt_c(t << 31);
        end
        return t[31:0];
    endfunction

    // five restoring square root steps
    function automatic t_sq sq_stage(input t_sq s_in);
        t_sq         s;
        logic [28:0] t_rem;
        logic [28:0] trial;
        s = s_in;
        for (int i = 0; i < SQ_STEPS; i++) begin
            t_rem = {s.rem, s.vsh[49:48]};
            trial = {2'b00, s.root, 2'b01};
            s.vsh = {s.vsh[47:0], 2'b00};
            if (t_rem >= trial) begin
                t_rem  = t_rem - trial;
                s.rem  = t_rem[26:0];
                s.root = {s.root[23:0], 1'b1};
            end else begin
                s.rem  = t_rem[26:0];
                s.root = {s.root[23:0], 1'b0};
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/exp_semicircle_kernel_eval.sv =====
// exp_semicircle_kernel_eval
// Evaluates exp(beta*sqrt(1 - c*x*x)) for one Q5.16 argument per transaction and
// returns it as a Q1.23 mantissa in [1,2) with a power-of-two exponent.
// Input channel: i_valid / o_stall with payload i_in_data. Output channel:
// o_valid / i_stall with payload o_out_data. A transaction happens at a rising
// edge with valid high and stall low. Arguments with 1 - c*x*x below zero give
// a zero result with out_of_support set; end_of_vector is carried along.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 beta_gain Q6.16, 1 width_scale Q1.24); write only while the pipe is empty.
// Throughput is one transaction per cycle while the output is not stalled:
// 34 pipeline stages (squaring, scale multiply, radicand, five square root
// stages of five bits, beta and log2(e) multiplies, 24 fraction multiplier
// stages) and an output register.
// A stalled output freezes the whole pipeline; o_stall rises only while a
// result is held in the output register and i_stall is high.
// Synchronous reset clears all valid bits and loads the default register values.
`default_nettype none
module exp_semicircle_kernel_eval (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire esk_pkg::t_in  i_in_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output esk_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [24:0]   i_cfg_data
);
    import esk_pkg::*;

    localparam int ST_RAD  = 2;
    localparam int ST_SQ0  = 3;
    localparam int ST_EXP0 = ST_SQ0 + SQ_STAGES + 2;
    localparam int NSTG    = ST_EXP0 + FRAC_W;

    logic [BETA_W-1:0]  r_beta;
    logic [SCALE_W-1:0] r_scale;

    logic r_vld [NSTG];
    logic r_out_vld;
    logic adv;

    t_tag r_tag [NSTG];
    t_tag n_tag [NSTG];

    logic [42:0] r_x2;
    logic [35:0] r_ph;
    logic [56:0] r_plo;
    logic [49:0] r_v;
    t_sq         r_sq [SQ_STAGES];
    t_sq         n_sq [SQ_STAGES];
    logic [46:0] r_bs;
    logic [61:0] r_zp;
    logic [31:0] r_m [FRAC_W];
    logic [31:0] n_m [FRAC_W];
    logic [FRAC_W-1:0] r_f [FRAC_W-1];
    t_out        r_out;
    t_out        n_out;

    logic [ARG_W-1:0] mag;
    logic [57:0]      q;
    logic [57:0]      rad;
    logic             oos;
    logic [31:0]      z;

    assign adv     = !(r_out_vld && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_out_vld;
    assign o_out_data = r_out;

    assign mag = i_in_data.arg_value[ARG_W-1] ?
                 (ARG_W'(0) - ARG_W'(i_in_data.arg_value)) : ARG_W'(i_in_data.arg_value);
    assign q   = {2'b00, r_ph[23:0], 32'h0} + {1'b0, r_plo};
    assign rad = ONE_Q56 - q;
    assign oos = (|r_ph[35:24]) || (q > ONE_Q56);
    assign z   = r_zp[61:30];

    // square root stages
    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
        if (j == 0) begin : g_first
            assign n_sq[j] = sq_stage('{rem: 27'd0, root: 25'd0, vsh: r_v});
        end else begin : g_next
            assign n_sq[j] = sq_stage(r_sq[j-1]);
        end
    end

    // fraction bits applied one per stage, most significant first
    for (genvar k = 0; k < FRAC_W; k++) begin : g_exp
        localparam logic [31:0] TAP = exp_tap(k + 1);
        logic [31:0]       m_in;
        logic [FRAC_W-1:0] f_in;
        logic [63:0]       prod;
        if (k == 0) begin : g_first
            assign m_in = 32'h8000_0000;
            assign f_in = z[FRAC_W-1:0];
        end else begin : g_next
            assign m_in = r_m[k-1];
            assign f_in = r_f[k-1];
        end
        assign prod   = 64'(m_in) * 64'(TAP);
        assign n_m[k] = f_in[FRAC_W-1-k] ? prod[62:31] : m_in;
    end

    always_comb begin
        for (int s = 0; s < NSTG; s++) begin
            if (s == 0) begin
                n_tag[s] = '{eov: i_in_data.end_of_vector, oos: 1'b0, sat: 1'b0,
                             expo: '0};
            end else begin
                n_tag[s] = r_tag[s-1];
            end
            if (s == ST_RAD) begin
                n_tag[s].oos = oos;
            end
            if (s == ST_EXP0) begin
                n_tag[s].sat  = |z[31:30];
                n_tag[s].expo = z[29:24];
            end
        end
    end

    always_comb begin
        n_out.end_of_vector_out = r_tag[NSTG-1].eov;
        n_out.out_of_support    = r_tag[NSTG-1].oos;
        if (r_tag[NSTG-1].oos) begin
            n_out.kernel_mantissa = '0;
            n_out.kernel_exponent = '0;
        end else if (r_tag[NSTG-1].sat) begin
            n_out.kernel_mantissa = MANT_MAX;
            n_out.kernel_exponent = EXPO_MAX;
        end else begin
            n_out.kernel_mantissa = r_m[FRAC_W-1][31:8];
            n_out.kernel_exponent = r_tag[NSTG-1].expo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta    <= BETA_RESET;
            r_scale   <= SCALE_RESET;
            r_out_vld <= 1'b0;
            for (int s = 0; s < NSTG; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BETA_GAIN:   r_beta  <= i_cfg_data[BETA_W-1:0];
                    CFG_WIDTH_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (adv) begin
                r_vld[0]  <= i_valid;
                for (int s = 1; s < NSTG; s++) begin
                    r_vld[s] <= r_vld[s-1];
                end
                r_out_vld <= r_vld[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < NSTG; s++) begin
                r_tag[s] <= n_tag[s];
            end
            r_x2  <= 43'(mag) * 43'(mag);
            r_ph  <= 36'(r_scale) * 36'(r_x2[42:32]);
            r_plo <= 57'(r_scale) * 57'(r_x2[31:0]);
            r_v   <= rad[57:8];
            for (int j = 0; j < SQ_STAGES; j++) begin
                r_sq[j] <= n_sq[j];
            end
            r_bs <= 47'(r_beta) * 47'(r_sq[SQ_STAGES-1].root);
            r_zp <= 62'(r_bs[46:16]) * 62'(LOG2E_Q30);
            r_f[0] <= z[FRAC_W-1:0];
            for (int k = 1; k < FRAC_W-1; k++) begin
                r_f[k] <= r_f[k-1];
            end
            for (int k = 0; k < FRAC_W; k++) begin
                r_m[k] <= n_m[k];
            end
            r_out <= n_out;
        end
    end

    a_oos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_data.out_of_support |->
            o_out_data.kernel_mantissa == '0 && o_out_data.kernel_exponent == '0)
        else $error("out of support result not zero");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_data.out_of_support |-> o_out_data.kernel_mantissa[23])
        else $error("mantissa not normalized");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_vld && i_stall)
        else $error("input stalled without a held result");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("valid result right after reset");

endmodule
`default_nettype wire

// ===== test/tb_exp_semicircle_kernel_eval.sv =====
`default_nettype none
module tb_exp_semicircle_kernel_eval;
    timeunit 1ns;
    timeprecision 1ps;
    import esk_pkg::*;

    localparam int LATENCY     = 35;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_in_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [24:0] i_cfg_data;

    exp_semicircle_kernel_eval dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in_data(i_in_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor copy of the registers
    logic [BETA_W-1:0]  beta_q;
    logic [SCALE_W-1:0] scale_q;

    t_out   kernel_q[$];
    int     n_errors;
    int     n_sent;
    int     n_oos;
    int     n_sat;
    int     n_results;
    longint cycles;
    bit     quiet;
    bit     hold_long;
    logic [31:0] tap_tab[1:24];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_exp_semicircle_kernel_eval: errors");
            $finish;
        end
    end

    function automatic logic [63:0] root64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = 0;
        b   = 64'h4000_0000_0000_0000;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_out kernel_of(input t_in item);
        t_out        r;
        logic [21:0] raw;
        logic [63:0] mag, x2, ph, q, s, y, z, m;
        logic [127:0] wide;
        raw = item.arg_value;
        mag = raw[21] ? 64'(23'h400000 - raw) : 64'(raw);
        x2  = mag * mag;
        ph  = 64'(scale_q) * (x2 >> 32);
        r   = '0;
        r.end_of_vector_out = item.end_of_vector;
        if (ph >= 64'd1 << 24) begin
            r.out_of_support = 1'b1;
            return r;
        end
        q = (ph << 32) + 64'(scale_q) * x2[31:0];
        if (q > 64'd1 << 56) begin
            r.out_of_support = 1'b1;
            return r;
        end
        s = root64(((64'd1 << 56) - q) >> 8);
        y = (64'(beta_q) * s) >> 16;
        wide = 128'(y) * 128'(LOG2E_Q30);
        z = 64'(wide >> 30);
        if ((z >> 24) > 63) begin
            r.kernel_exponent = EXPO_MAX;
            r.kernel_mantissa = MANT_MAX;
        end else begin
            r.kernel_exponent = 6'(z >> 24);
            m = 64'd1 << 31;
            for (int k = 1; k <= 24; k++)
                if (z[24-k]) m = (m * 64'(tap_tab[k])) >> 31;
            r.kernel_mantissa = 24'(m >> 8);
        end
        return r;
    endfunction

    task automatic send_arg(input logic signed [21:0] x, input logic eov);
        t_in item;
        item.arg_value     = x;
        item.end_of_vector = eov;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_stall);
        kernel_q.push_back(kernel_of(item));
        n_sent++;
    endtask

    // sink side: i_stall held high during hold_long, else random one time in five unless quiet
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else if (hold_long)
            i_stall <= 1'b1;
        else if (!quiet && $urandom_range(0, 4) == 0)
            i_stall <= 1'b1;
        else
            i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (kernel_q.size() == 0) begin
                $error("result transaction with nothing expected");
                n_errors++;
            end else begin
                want = kernel_q.pop_front();
                if (o_out_data.out_of_support) n_oos++;
                if (o_out_data.kernel_exponent == EXPO_MAX) n_sat++;
                if (o_out_data.kernel_mantissa !== want.kernel_mantissa) begin
                    $error("kernel_mantissa exp %0h got %0h",
                           want.kernel_mantissa, o_out_data.kernel_mantissa);
                    n_errors++;
                end
                if (o_out_data.kernel_exponent !== want.kernel_exponent) begin
                    $error("kernel_exponent exp %0d got %0d",
                           want.kernel_exponent, o_out_data.kernel_exponent);
                    n_errors++;
                end
                if (o_out_data.out_of_support !== want.out_of_support) begin
                    $error("out_of_support exp %0b got %0b",
                           want.out_of_support, o_out_data.out_of_support);
                    n_errors++;
                end
                if (o_out_data.end_of_vector_out !== want.end_of_vector_out) begin
                    $error("end_of_vector_out exp %0b got %0b",
                           want.end_of_vector_out, o_out_data.end_of_vector_out);
                    n_errors++;
                end
            end
        end
    end

    task automatic drain;
        i_valid <= 1'b0;
        while (kernel_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [24:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BETA_GAIN) beta_q = val[21:0];
        else scale_q = val;
        @(posedge i_clk);
    endtask

    function automatic logic signed [21:0] rand_arg;
        if ($urandom_range(0, 3) == 0) return 22'($urandom);
        // mostly inside support for the reset width
        return 22'(int'($urandom_range(0, 720000)) - 360000);
    endfunction

    task automatic test_directed;
        send_arg(22'sd0, 1'b0);
        send_arg(22'sh1FFFFF, 1'b1);
        send_arg(22'sh200000, 1'b0);
        send_arg(22'sd1, 1'b0);
        send_arg(-22'sd1, 1'b1);
        // edge of support for c = 4/121: x = 5.5
        send_arg(22'sd360448, 1'b0);
        send_arg(22'sd360449, 1'b0);
        send_arg(-22'sd360448, 1'b1);
        drain();
        // c = 1.0: radicand exactly zero at x = 1
        write_reg(CFG_WIDTH_SCALE, 25'd16777216);
        send_arg(22'sd65536, 1'b0);
        send_arg(-22'sd65536, 1'b1);
        send_arg(22'sd65537, 1'b0);
        send_arg(22'sd32768, 1'b0);
        drain();
        // saturation with beta above 44.36, c = 0
        write_reg(CFG_BETA_GAIN, 25'h3FFFFF);
        write_reg(CFG_WIDTH_SCALE, 25'd0);
        send_arg(22'sd0, 1'b0);
        send_arg(22'sh1FFFFF, 1'b1);
        drain();
        write_reg(CFG_BETA_GAIN, 25'd0);
        send_arg(22'sd12345, 1'b0);
        send_arg(22'sh200000, 1'b1);
        drain();
        // data bits above the width of the beta_gain register
        write_reg(CFG_WIDTH_SCALE, 25'h1FFFFFF);
        write_reg(CFG_BETA_GAIN, 25'h1C00000 | 25'd2621440);
        send_arg(22'sd100, 1'b0);
        send_arg(22'sd4000, 1'b1);
        drain();
    endtask

    task automatic test_random_phase(input logic [24:0] beta, input logic [24:0] scale,
                                     input int count);
        write_reg(CFG_BETA_GAIN, beta);
        write_reg(CFG_WIDTH_SCALE, scale);
        for (int i = 0; i < count; i++)
            send_arg(rand_arg(), 1'($urandom_range(0, 7) == 0));
        drain();
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_long = 1'b1;
                repeat (80) @(posedge i_clk);
                hold_long = 1'b0;
            end
            for (int i = 0; i < 60; i++) send_arg(rand_arg(), 1'b0);
        join
        drain();
    endtask

    initial begin
        for (int k = 1; k <= 24; k++) begin
            logic [63:0] t;
            t = root64(64'h8000_0000_0000_0000);
            for (int j = 2; j <= k; j++) t = root64(t << 31);
            tap_tab[k] = t[31:0];
        end
        cycles = 0; n_errors = 0; n_sent = 0; n_oos = 0; n_sat = 0; n_results = 0;
        quiet = 1'b0; hold_long = 1'b0;
        beta_q = BETA_RESET; scale_q = SCALE_RESET;
        i_rst_n = 1'b0; i_valid = 1'b0; i_in_data = '0;
        i_cfg_we = 1'b0; i_cfg_index = CFG_BETA_GAIN; i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(25'd1658061, 25'd554619, 350);
        test_random_phase(25'd2621440, 25'd16777216, 250);
        test_random_phase(25'd0, 25'd1000, 150);
        test_backpressure();
        test_random_phase(25'($urandom_range(0, 2621440)),
                          25'($urandom_range(0, 16777216)), 150);
        quiet = 1'b1;
        test_random_phase(25'd1658061, 25'd554619, 200);
        $display("sent %0d arguments, checked %0d results", n_sent, n_results);
        $display("(%0d outside support, %0d at max exponent)", n_oos, n_sat);
        if (n_errors == 0)
            $display("tb_exp_semicircle_kernel_eval: clean");
        else
            $display("tb_exp_semicircle_kernel_eval: errors");
        $finish;
    end
endmodule
`default_nettype wire
